@@ hdl/edsp_pkg.sv @@
// Shared types and constants for the DER ECDSA signature parser.
`timescale 1ns / 1ps
`default_nettype none
package edsp_pkg;

	localparam logic [7:0] SEQ_TAG  = 8'h30;
	localparam logic [7:0] INT_TAG  = 8'h02;
	localparam logic [7:0] PAD_BYTE = 8'h00;

	typedef enum logic [3:0] {
		PH_SEQ_TAG = 4'd0,
		PH_SEQ_LEN = 4'd1,
		PH_INT_TAG = 4'd2,
		PH_INT_LEN = 4'd3,
		PH_FIRST   = 4'd4,
		PH_PAYLOAD = 4'd5,
		PH_DONE    = 4'd6,
		PH_ERROR   = 4'd7
	} phase_t;

	typedef enum logic [1:0] {
		ERR_SEQ_TAG = 2'd0,
		ERR_INT_TAG = 2'd1,
		ERR_LENGTH  = 2'd2
	} err_code_t;

	typedef struct packed {
		phase_t     phase;
		logic [5:0] bytes_remaining;
		logic [5:0] position_count;
		logic       current_integer;
	} parse_state_t;

	typedef struct packed {
		logic       which_integer;
		logic [7:0] payload_byte;
		logic [5:0] byte_position;
		logic       integer_last;
		logic       signature_done;
		logic       error_flag;
		err_code_t  error_code;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/edsp_step.sv @@
// Next-state and result logic for one signature byte.
`timescale 1ns / 1ps
`default_nettype none
module edsp_step #(
	parameter int MAX_INT_BYTES = 33
) (
	input  wire logic [7:0]            data_byte,
	input  wire logic                  frame_start,
	input  wire logic                  expect_sequence_length,
	input  wire edsp_pkg::parse_state_t cur,
	output edsp_pkg::parse_state_t     nxt,
	output logic                       res_valid,
	output edsp_pkg::result_t          res
);
	import edsp_pkg::*;

	localparam logic [7:0] MaxLen = 8'(MAX_INT_BYTES);

	parse_state_t st;
	logic         last;

	always_comb begin
		st = cur;
		if (frame_start) begin
			st.phase           = PH_SEQ_TAG;
			st.bytes_remaining = '0;
			st.position_count  = '0;
			st.current_integer = 1'b0;
		end

		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		res.which_integer = st.current_integer;
		last      = (st.bytes_remaining == '0);

		case (st.phase)
			PH_SEQ_TAG: begin
				if (data_byte != SEQ_TAG) begin
					nxt.phase      = PH_ERROR;
					res_valid      = 1'b1;
					res.error_flag = 1'b1;
					res.error_code = ERR_SEQ_TAG;
				end else begin
					nxt.phase = expect_sequence_length ? PH_SEQ_LEN : PH_INT_TAG;
				end
			end
			PH_SEQ_LEN: begin
				nxt.phase = PH_INT_TAG;
			end
			PH_INT_TAG: begin
				if (data_byte != INT_TAG) begin
					nxt.phase      = PH_ERROR;
					res_valid      = 1'b1;
					res.error_flag = 1'b1;
					res.error_code = ERR_INT_TAG;
				end else begin
					nxt.phase = PH_INT_LEN;
				end
			end
			PH_INT_LEN: begin
				if (data_byte == 8'd0 || data_byte > MaxLen) begin
					nxt.phase      = PH_ERROR;
					res_valid      = 1'b1;
					res.error_flag = 1'b1;
					res.error_code = ERR_LENGTH;
				end else begin
					nxt.bytes_remaining = 6'(data_byte - 8'd1);
					nxt.position_count  = '0;
					nxt.phase           = PH_FIRST;
				end
			end
			PH_FIRST, PH_PAYLOAD: begin
				if (st.phase == PH_FIRST && data_byte == PAD_BYTE && !last) begin
					// drop the leading pad byte
					nxt.bytes_remaining = st.bytes_remaining - 6'd1;
					nxt.phase           = PH_PAYLOAD;
				end else begin
					res_valid          = 1'b1;
					res.payload_byte   = data_byte;
					res.byte_position  = st.position_count;
					res.integer_last   = last;
					res.signature_done = last & st.current_integer;
					nxt.position_count = st.position_count + 6'd1;
					if (last) begin
						if (st.current_integer) begin
							nxt.phase = PH_DONE;
						end else begin
							nxt.current_integer = 1'b1;
							nxt.phase           = PH_INT_TAG;
						end
					end else begin
						nxt.bytes_remaining = st.bytes_remaining - 6'd1;
						nxt.phase           = PH_PAYLOAD;
					end
				end
			end
			default: begin
				// done or error: ignore bytes until the next frame start
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/edsp_out_reg.sv @@
// Result register with valid/ready hand-off to the receiver.
`timescale 1ns / 1ps
`default_nettype none
module edsp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              load,
	input  wire edsp_pkg::result_t load_data,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   can_take,
	output edsp_pkg::result_t      out_data
);
	import edsp_pkg::*;

	logic    valid_q;
	result_t data_q;

	// a new word may enter when the slot is empty or is being drained
	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			data_q <= load_data;
		end
	end

endmodule
`default_nettype wire

@@ hdl/ecdsa_der_signature_parser_top.sv @@
// DER ECDSA signature parser: one byte in per word, r and s payload bytes out.
//
// Input channel: data_byte with frame_start on the first byte of a signature,
// moved by in_valid/in_ready. Output channel: one result word per payload byte
// of r or s (pad byte dropped), or one error word, moved by out_valid/out_ready.
// Bytes that yield no result (tags, lengths, pad, trailing or post-error bytes)
// are consumed silently.
// Throughput: one input byte per clock while in_ready is high. Each result is
// held in one result register, valid in the cycle after its byte is accepted.
// When the receiver stalls, in_ready stays high while the result register is
// empty or being drained this cycle, so parsing continues up to one word ahead.
// Reset: parser waits for the sequence tag, result register empty, and
// expect_sequence_length set to 1. cfg_write_en writes cfg_write_data into that
// mode bit at any clock edge; change it only while the parser is idle.
`timescale 1ns / 1ps
`default_nettype none
module ecdsa_der_signature_parser_top #(
	parameter int MAX_INT_BYTES = 33
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_en,
	input  wire logic       cfg_write_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_start,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            which_integer,
	output logic [7:0]      payload_byte,
	output logic [5:0]      byte_position,
	output logic            integer_last,
	output logic            signature_done,
	output logic            error_flag,
	output logic [1:0]      error_code
);
	import edsp_pkg::*;

	logic         expect_seq_len_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         res_valid;
	result_t      res;
	result_t      out_data;
	logic         accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_seq_len_q <= 1'b1;
		end else if (cfg_write_en) begin
			expect_seq_len_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SEQ_TAG, bytes_remaining: '0,
				position_count: '0, current_integer: 1'b0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	edsp_step #(
		.MAX_INT_BYTES(MAX_INT_BYTES)
	) u_step (
		.data_byte              (data_byte),
		.frame_start            (frame_start),
		.expect_sequence_length (expect_seq_len_q),
		.cur                    (state_q),
		.nxt                    (state_nxt),
		.res_valid              (res_valid),
		.res                    (res)
	);

	edsp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.load      (res_valid),
		.load_data (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_take  (in_ready),
		.out_data  (out_data)
	);

	assign which_integer  = out_data.which_integer;
	assign payload_byte   = out_data.payload_byte;
	assign byte_position  = out_data.byte_position;
	assign integer_last   = out_data.integer_last;
	assign signature_done = out_data.signature_done;
	assign error_flag     = out_data.error_flag;
	assign error_code     = out_data.error_code;

endmodule
`default_nettype wire

@@ sim/edsp_checker.sv @@
// Watches both channels of the signature parser, predicts each result word and compares.
`timescale 1ns / 1ps
module edsp_checker #(
	parameter int MAX_INT_BYTES = 33
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_en,
	input  wire logic       cfg_write_data,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_start,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic       which_integer,
	input  wire logic [7:0] payload_byte,
	input  wire logic [5:0] byte_position,
	input  wire logic       integer_last,
	input  wire logic       signature_done,
	input  wire logic       error_flag,
	input  wire logic [1:0] error_code,
	output int              mismatches,
	output int              pending,
	output int              words_seen,
	output int              error_words
);
	import edsp_pkg::*;

	logic       seq_len_mode;
	phase_t     phase;
	logic [5:0] remaining;
	logic [5:0] position;
	logic       cur_int;
	result_t    expected_words[$];
	result_t    got;
	result_t    want;
	result_t    fresh;

	// Advance the parse state by one byte; return 1 when the byte yields a result word.
	function automatic bit decode_byte(input logic [7:0] b, input logic fs, output result_t r);
		bit        bad;
		bit        data;
		bit        last;
		err_code_t code;
		bad = 1'b0;
		data = 1'b0;
		code = ERR_SEQ_TAG;
		r = '0;
		if (fs) begin
			phase = PH_SEQ_TAG;
			remaining = '0;
			position = '0;
			cur_int = 1'b0;
		end
		case (phase)
			PH_SEQ_TAG: begin
				if (b != SEQ_TAG) begin
					bad = 1'b1;
					code = ERR_SEQ_TAG;
				end else if (seq_len_mode) begin
					phase = PH_SEQ_LEN;
				end else begin
					phase = PH_INT_TAG;
				end
			end
			PH_SEQ_LEN: phase = PH_INT_TAG;
			PH_INT_TAG: begin
				if (b != INT_TAG) begin
					bad = 1'b1;
					code = ERR_INT_TAG;
				end else begin
					phase = PH_INT_LEN;
				end
			end
			PH_INT_LEN: begin
				if (b == 8'd0 || int'(b) > MAX_INT_BYTES) begin
					bad = 1'b1;
					code = ERR_LENGTH;
				end else begin
					remaining = 6'(b - 8'd1);
					position = '0;
					phase = PH_FIRST;
				end
			end
			PH_FIRST: begin
				// drop a leading pad only when more bytes follow it
				if (b == PAD_BYTE && remaining != 6'd0) begin
					remaining = remaining - 6'd1;
					phase = PH_PAYLOAD;
				end else begin
					data = 1'b1;
				end
			end
			PH_PAYLOAD: data = 1'b1;
			default: ;
		endcase
		if (bad) begin
			phase = PH_ERROR;
			r.which_integer = cur_int;
			r.error_flag = 1'b1;
			r.error_code = code;
			return 1'b1;
		end
		if (!data)
			return 1'b0;
		last = (remaining == 6'd0);
		r.which_integer = cur_int;
		r.payload_byte = b;
		r.byte_position = position;
		r.integer_last = last;
		r.signature_done = last & cur_int;
		position = position + 6'd1;
		if (!last) begin
			remaining = remaining - 6'd1;
			phase = PH_PAYLOAD;
		end else if (cur_int) begin
			phase = PH_DONE;
		end else begin
			cur_int = 1'b1;
			phase = PH_INT_TAG;
		end
		return 1'b1;
	endfunction

	function automatic string fmt_word(input result_t w);
		return $sformatf("int=%0d byte=%02h pos=%0d last=%0d done=%0d err=%0d code=%0d",
			w.which_integer, w.payload_byte, w.byte_position, w.integer_last,
			w.signature_done, w.error_flag, w.error_code);
	endfunction

	task automatic flag_problem(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_mode = 1'b1;
			phase = PH_SEQ_TAG;
			remaining = '0;
			position = '0;
			cur_int = 1'b0;
			expected_words.delete();
			mismatches = 0;
			pending = 0;
			words_seen = 0;
			error_words = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {which_integer, payload_byte, byte_position, integer_last,
					signature_done, error_flag, error_code};
				words_seen++;
				if (got.error_flag)
					error_words++;
				if (expected_words.size() == 0) begin
					flag_problem($sformatf("result word with none expected: %s", fmt_word(got)));
				end else begin
					want = expected_words.pop_front();
					if (got !== want)
						flag_problem($sformatf("word %0d mismatch\n  expected %s\n  got      %s",
							words_seen, fmt_word(want), fmt_word(got)));
				end
			end
			// a byte taken at this edge still sees the old mode bit
			if (in_valid && in_ready) begin
				if (decode_byte(data_byte, frame_start, fresh))
					expected_words.insert(expected_words.size(), fresh);
			end
			if (cfg_write_en)
				seq_len_mode = cfg_write_data;
			pending = expected_words.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top for the DER ECDSA signature parser: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb;
	import edsp_pkg::*;

	localparam int MAX_LEN = 33;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_write_en;
	logic       cfg_write_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       frame_start;
	logic       out_valid;
	logic       out_ready;
	logic       which_integer;
	logic [7:0] payload_byte;
	logic [5:0] byte_position;
	logic       integer_last;
	logic       signature_done;
	logic       error_flag;
	logic [1:0] error_code;
	int         mismatches;
	int         pending;
	int         words_seen;
	int         error_words;

	logic mode_now;
	bit   tx_quiet;
	bit   rx_quiet;
	int   n_framed;
	int   n_frames;
	int   n_settings;

	ecdsa_der_signature_parser_top #(.MAX_INT_BYTES(MAX_LEN)) DUT (.*);

	edsp_checker #(.MAX_INT_BYTES(MAX_LEN)) u_check (.*);

	always #1 clk = ~clk;

	initial begin
		#1000000;
		$display("tb NOT OK");
		$finish;
	end

	// Receiver: stall a random number of cycles before taking each word.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		frame_start = fs;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_seq(input logic [7:0] bytes[$], input logic lead_fs, input int restart_at);
		foreach (bytes[i])
			send_byte(bytes[i], (i == 0) ? lead_fs : (i == restart_at));
		n_framed += bytes.size();
		n_frames++;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	// Mostly well-formed signatures with random content; some get one flaw.
	task automatic send_random_frame();
		logic [7:0] q[$];
		int         tag_at[2];
		int         len_at[2];
		int         flaw;
		int         len;
		int         cut;
		int         restart_at;
		logic [7:0] v;
		logic       with_len;
		tx_quiet = ($urandom_range(0, 3) == 0);
		rx_quiet = ($urandom_range(0, 3) == 0);
		flaw = ($urandom_range(0, 99) < 25) ? $urandom_range(0, 5) : -1;
		restart_at = -1;
		// flaw 5: frame laid out for the other sequence-length mode
		with_len = (flaw == 5) ? !mode_now : mode_now;
		q.insert(q.size(), SEQ_TAG);
		if (with_len)
			q.insert(q.size(), 8'($urandom_range(0, 255)));
		for (int i = 0; i < 2; i++) begin
			tag_at[i] = q.size();
			q.insert(q.size(), INT_TAG);
			case ($urandom_range(0, 19))
				0: len = MAX_LEN;
				1: len = MAX_LEN - 1;
				default: len = $urandom_range(1, 8);
			endcase
			len_at[i] = q.size();
			q.insert(q.size(), 8'(len));
			for (int k = 0; k < len; k++) begin
				v = 8'($urandom_range(0, 255));
				if (k == 0 && $urandom_range(0, 2) == 0)
					v = PAD_BYTE;
				q.insert(q.size(), v);
			end
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) q.insert(q.size(), 8'($urandom_range(0, 255)));
		case (flaw)
			0: begin
				v = 8'($urandom_range(0, 255));
				q[0] = (v == SEQ_TAG) ? (SEQ_TAG ^ 8'h01) : v;
			end
			1: begin
				v = 8'($urandom_range(0, 255));
				q[tag_at[$urandom_range(0, 1)]] = (v == INT_TAG) ? (INT_TAG ^ 8'h01) : v;
			end
			2: q[len_at[$urandom_range(0, 1)]] =
				($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(MAX_LEN + 1, 255));
			3: begin
				cut = $urandom_range(1, q.size() - 1);
				while (q.size() > cut)
					void'(q.pop_back());
			end
			4: restart_at = $urandom_range(1, q.size() - 1);
			default: ;
		endcase
		send_seq(q, 1'b1, restart_at);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending != 0 || out_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input logic v);
		wait_idle();
		cfg_write_en = 1'b1;
		cfg_write_data = v;
		mode_now = v;
		@(negedge clk);
		cfg_write_en = 1'b0;
		n_settings++;
	endtask

	task automatic run_random(input int target);
		while (n_framed < target) begin
			if ($urandom_range(0, 11) == 0)
				send_noise();
			else
				send_random_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		frame_start = 1'b0;
		mode_now = 1'b1;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		n_framed = 0;
		n_frames = 0;
		n_settings = 1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no frame_start after reset; pad dropped in s; trailing byte ignored
		send_seq('{SEQ_TAG, 8'h44, INT_TAG, 8'h01, 8'h05, INT_TAG, 8'h02, PAD_BYTE, 8'h80,
			8'hAA}, 1'b0, -1);
		// one-byte zero integer, then zero length and a byte after the error
		send_seq('{SEQ_TAG, 8'h06, INT_TAG, 8'h01, PAD_BYTE, INT_TAG, 8'h00, 8'hFF}, 1'b1, -1);
		send_seq('{SEQ_TAG ^ 8'h01}, 1'b1, -1);
		send_seq('{SEQ_TAG, 8'hFF, 8'h05}, 1'b1, -1);
		send_seq('{SEQ_TAG, 8'h00, INT_TAG, 8'(MAX_LEN + 1)}, 1'b1, -1);
		run_random(170);

		set_mode(1'b0);
		send_seq('{SEQ_TAG, INT_TAG, 8'h01, 8'h7F, INT_TAG, 8'h01, 8'h01}, 1'b1, -1);
		run_random(340);

		set_mode(1'b1);
		run_random(430);

		set_mode(1'b0);
		run_random(520);

		in_valid = 1'b0;
		while (pending != 0 || out_valid)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d signature bytes in %0d frames over %0d mode settings;",
			n_framed, n_frames, n_settings);
		$display("checked %0d result words, %0d of them error reports, %0d left unmatched.",
			words_seen, error_words, pending);
		if (mismatches == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hdl/edsp_pkg.sv
hdl/edsp_step.sv
hdl/edsp_out_reg.sv
hdl/ecdsa_der_signature_parser_top.sv
sim/edsp_checker.sv
sim/tb.sv
